FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Check that an antecedent implies a consequent sequence
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: rtl/opsm_pkg.sv
// ----------------------------------------------------------------------------
// opsm_pkg
// Shared types, codes and constants of the object pool slot manager.
// ----------------------------------------------------------------------------
package opsm_pkg;

	localparam int SLOT_DEPTH_DEF = 256;
	localparam int INDEX_SPAN     = 256;

	localparam int OP_W     = 3;
	localparam int IDX_W    = 8;
	localparam int ST_W     = 3;
	localparam int ADDR_W   = 32;
	localparam int CNT_W    = 9;
	localparam int CAP_W    = 9;
	localparam int OBJ_W    = 16;
	localparam int CFG_W    = 32;
	localparam int CFGIDX_W = 2;
	localparam int PROD_W   = IDX_W + OBJ_W;

	localparam int IN_W  = 16;
	localparam int OUT_W = 56;

	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
	localparam logic [OBJ_W-1:0] OBJ_RESET = 16'd64;
	localparam logic [ADDR_W-1:0] BASE_RESET = 32'd0;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 3'd0,
		OP_FREE  = 3'd1,
		OP_FIRST = 3'd2,
		OP_NEXT  = 3'd3,
		OP_CLEAR = 3'd4,
		OP_ADDR  = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_RANGE  = 3'd2,
		ST_NOTACT = 3'd3,
		ST_NONE   = 3'd4
	} status_t;

	typedef enum logic [CFGIDX_W-1:0] {
		CFG_CAPACITY = 2'd0,
		CFG_OBJ_SIZE = 2'd1,
		CFG_BASE     = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_stall;
	} stat_t;

endpackage

FILE: rtl/opsm_ram.sv
// ----------------------------------------------------------------------------
// opsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module opsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/opsm_ctrl.sv
// ----------------------------------------------------------------------------
// opsm_ctrl
// Command sequencer: accept, execute, then present the result.
// ----------------------------------------------------------------------------
module opsm_ctrl import opsm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_stall) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.load    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_DONE: begin
				cmd.load = !stat.out_stall;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/opsm_dp.sv
// ----------------------------------------------------------------------------
// opsm_dp
// Datapath: registers, free stack, active flags, search tree, address unit.
// ----------------------------------------------------------------------------
module opsm_dp import opsm_pkg::*; #(
	parameter int SLOT_DEPTH = SLOT_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFGIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic [IN_W-1:0]     s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata,
	input  cmd_t                cmd,
	output stat_t               stat
);

	localparam int FLAG_N = (SLOT_DEPTH < INDEX_SPAN) ? SLOT_DEPTH : INDEX_SPAN;
	localparam int FW     = (FLAG_N > 1) ? $clog2(FLAG_N) : 1;
	localparam int NG     = (FLAG_N + 15) / 16;
	localparam int GW     = (NG > 1) ? $clog2(NG) : 1;
	localparam int SW     = $clog2(SLOT_DEPTH);
	localparam int DW     = SW + 1;
	localparam logic [CAP_W-1:0] FLAG_CAP = CAP_W'(FLAG_N);
	localparam logic [DW-1:0]    STACK_FULL = DW'(SLOT_DEPTH);

	// configuration
	logic [CAP_W-1:0]  cap_q;
	logic [OBJ_W-1:0]  obj_q;
	logic [ADDR_W-1:0] base_q;
	logic [CAP_W-1:0]  cap_eff;
	logic [CAP_W-1:0]  cfg_cap_eff;

	// pool state
	logic [FLAG_N-1:0] flags_q;
	logic [DW-1:0]     depth_q;
	logic [CAP_W-1:0]  fresh_q;
	logic [CNT_W-1:0]  count_q;

	// captured command and first search stage
	logic [OP_W-1:0]   op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [NG-1:0]     any_s1;
	logic [3:0]        off_s1 [NG];

	// execute results
	logic [ST_W-1:0]   st_q;
	logic              addrv_q;
	logic [IDX_W-1:0]  res_q;
	logic [PROD_W-1:0] prod_q;

	// output register
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	// stack memory
	logic              push;
	logic [IDX_W-1:0]  pop_data;
	logic [SW-1:0]     pop_addr;
	logic [DW-1:0]     depth_m1;

	assign cap_eff     = (cap_q > FLAG_CAP) ? FLAG_CAP : cap_q;
	assign cfg_cap_eff = (cfg_wdata[CAP_W-1:0] > FLAG_CAP) ? FLAG_CAP : cfg_wdata[CAP_W-1:0];
	assign depth_m1    = depth_q - DW'(1);
	assign pop_addr    = depth_m1[SW-1:0];

	opsm_ram #(
		.WIDTH (IDX_W),
		.DEPTH (SLOT_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (push),
		.waddr (depth_q[SW-1:0]),
		.wdata (idx_q),
		.raddr (pop_addr),
		.rdata (pop_data)
	);

	// ---- search stage one: mask flags by window, encode each group of 16
	logic [CAP_W-1:0]  start;
	logic [NG*16-1:0]  window;
	logic [NG-1:0]     any_d;
	logic [3:0]        off_d [NG];

	always_comb begin
		start = '0;
		if (s_tdata[OP_W-1:0] == OP_NEXT) begin
			start = {1'b0, s_tdata[OP_W +: IDX_W]} + CAP_W'(1);
		end
		window = '0;
		for (int i = 0; i < FLAG_N; i++) begin
			window[i] = flags_q[i] && (CAP_W'(i) >= start) && (CAP_W'(i) < cap_eff);
		end
		for (int g = 0; g < NG; g++) begin
			any_d[g] = |window[g*16 +: 16];
			off_d[g] = '0;
			for (int b = 15; b >= 0; b--) begin
				if (window[g*16 + b]) off_d[g] = 4'(b);
			end
		end
	end

	// ---- search stage two: first group that holds a hit
	logic              found;
	logic [IDX_W-1:0]  found_idx;
	logic [GW+3:0]     found_w;

	always_comb begin
		found   = 1'b0;
		found_w = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (any_s1[g]) begin
				found   = 1'b1;
				found_w = {GW'(g), off_s1[g]};
			end
		end
		found_idx = IDX_W'(found_w);
	end

	// ---- execute decode
	logic              idx_in;
	logic              flag_at;
	logic [IDX_W-1:0]  cand;
	logic              have_cand;
	logic              do_pop;
	logic              do_fresh;
	logic              do_set;
	logic              do_clr;
	logic              do_clear;
	logic [ST_W-1:0]   st_d;
	logic              addrv_d;
	logic [IDX_W-1:0]  res_d;
	logic [FW-1:0]     set_idx;

	assign idx_in  = {1'b0, idx_q} < cap_eff;
	assign flag_at = flags_q[idx_q[FW-1:0]];

	always_comb begin
		cand      = '0;
		have_cand = 1'b0;
		do_pop    = 1'b0;
		do_fresh  = 1'b0;
		do_set    = 1'b0;
		do_clr    = 1'b0;
		do_clear  = 1'b0;
		push      = 1'b0;
		st_d      = ST_OK;
		addrv_d   = 1'b0;
		res_d     = '0;
		unique case (op_q)
			OP_ALLOC: begin
				if (depth_q != '0) begin
					do_pop    = 1'b1;
					have_cand = 1'b1;
					cand      = pop_data;
				end else if (fresh_q != '0) begin
					do_fresh  = 1'b1;
					have_cand = 1'b1;
					cand      = IDX_W'(fresh_q - CAP_W'(1));
				end
				if (have_cand && ({1'b0, cand} < cap_eff)) begin
					do_set  = 1'b1;
					res_d   = cand;
					addrv_d = 1'b1;
				end else begin
					st_d = ST_EMPTY;
				end
			end
			OP_FREE: begin
				if (!idx_in) begin
					st_d = ST_RANGE;
				end else if (!flag_at) begin
					st_d = ST_NOTACT;
				end else if (depth_q < STACK_FULL) begin
					do_clr = 1'b1;
					push   = cmd.exec;
				end
			end
			OP_FIRST, OP_NEXT: begin
				if (found) begin
					res_d   = found_idx;
					addrv_d = 1'b1;
				end else begin
					st_d = ST_NONE;
				end
			end
			OP_CLEAR: begin
				do_clear = 1'b1;
			end
			OP_ADDR: begin
				if (!idx_in) begin
					st_d = ST_RANGE;
				end else begin
					res_d   = idx_q;
					addrv_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
		set_idx = do_set ? cand[FW-1:0] : idx_q[FW-1:0];
	end

	// ---- control state: configuration and pool bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			obj_q   <= OBJ_RESET;
			base_q  <= BASE_RESET;
			flags_q <= '0;
			depth_q <= '0;
			fresh_q <= (CAP_RESET > FLAG_CAP) ? FLAG_CAP : CAP_RESET;
			count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAPACITY: begin
					cap_q   <= cfg_wdata[CAP_W-1:0];
					flags_q <= '0;
					depth_q <= '0;
					fresh_q <= cfg_cap_eff;
					count_q <= '0;
				end
				CFG_OBJ_SIZE: obj_q  <= cfg_wdata[OBJ_W-1:0];
				CFG_BASE:     base_q <= cfg_wdata[ADDR_W-1:0];
				default: begin
				end
			endcase
		end else if (cmd.exec) begin
			if (do_clear) begin
				flags_q <= '0;
				depth_q <= '0;
				fresh_q <= cap_eff;
				count_q <= '0;
			end else begin
				if (do_pop)   depth_q <= depth_m1;
				if (do_fresh) fresh_q <= fresh_q - CAP_W'(1);
				if (do_set) begin
					flags_q[set_idx] <= 1'b1;
					count_q          <= count_q + CNT_W'(1);
				end
				if (do_clr) begin
					flags_q[set_idx] <= 1'b0;
					depth_q          <= depth_q + DW'(1);
					if (count_q != '0) count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	// ---- payload registers: command capture, execute results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= s_tdata[OP_W-1:0];
			idx_q  <= s_tdata[OP_W +: IDX_W];
			any_s1 <= any_d;
			off_s1 <= off_d;
		end
		if (cmd.exec) begin
			st_q    <= st_d;
			addrv_q <= addrv_d;
			res_q   <= res_d;
			prod_q  <= PROD_W'(res_d) * PROD_W'(obj_q);
		end
		if (cmd.load) begin
			out_data_q <= {
				(OUT_W - ST_W - IDX_W - ADDR_W - CNT_W)'(0),
				count_q,
				addrv_q ? (base_q + ADDR_W'(prod_q)) : ADDR_W'(0),
				res_q,
				st_q
			};
		end
	end

	// ---- output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid       = out_valid_q;
	assign m_tdata        = out_data_q;
	assign stat.out_stall = out_valid_q && !m_tready;

endmodule

FILE: rtl/object_pool_slot_manager.sv
// ----------------------------------------------------------------------------
// object_pool_slot_manager
// LIFO slot allocator over a pool of fixed-size objects.
//
// Commands arrive on the s_ stream (opcode, entry index); each gives exactly
// one result item on the m_ stream (status, index, byte address, active
// count). Fresh slots are handed out from the top index down, freed slots
// are reused first, newest first.
// Sequence: an item is taken in the idle state, executed in the execute state
// and its result loaded into the output register in the done state once that
// register is free; no new item is taken before that load. The sequence is
// set by the registered read of the free stack memory and the two-stage
// first-active search tree.
// Stall: the result waits in the output register; a new item is still taken
// and executed, then held in the final step until the register drains.
// Reset: capacity 256 (clamped to the built depth), stride 64, base 0; all
// slots inactive, stack empty. Writing the capacity register also clears the
// pool. Configure only while no item is outstanding.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module object_pool_slot_manager import opsm_pkg::*; #(
	parameter int SLOT_DEPTH = SLOT_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_we,
	input  logic [CFGIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]    cfg_wdata,
	// command stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_W-1:0]     s_tdata,  // opcode[2:0], entry_index[10:3], zero pad
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata   // status[2:0], result_index[10:3],
	                                      // slot_address[42:11], active_total[51:43]
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer: idle, execute, present
	opsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// pool state, free stack, search and address arithmetic
	opsm_dp #(
		.SLOT_DEPTH (SLOT_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

	// the sequencer holds off further items while one is in flight
	`ASSERT_IMPLY(a_busy_after_accept, s_tvalid && s_tready, ##1 !s_tready,
		"item accepted while previous still executing")
	// every accepted item is followed by a valid result on the output
	`ASSERT_IMPLY(a_result_follows, s_tvalid && s_tready, ##3 m_tvalid,
		"no result after accepted item")
	// status code and active count stay within their ranges
	`ASSERT_ALWAYS(a_result_range,
		!m_tvalid || ((m_tdata[2:0] <= ST_NONE) && (m_tdata[51:43] <= 9'd256)),
		"result field out of range")

endmodule

FILE: verif/slot_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_result_checker
// Follows register writes and accepted commands of the slot manager with its
// own pool state, and compares every accepted result with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module slot_result_checker import opsm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFGIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [IN_W-1:0]     s_tdata,  // opcode[2:0], entry_index[10:3], zero pad
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OUT_W-1:0]    m_tdata,  // status[2:0], result_index[10:3],
	                                      // slot_address[42:11], active_total[51:43]
	output int                  mismatches,
	output int                  awaited,
	output int                  checked
);

	localparam int REPORT_MAX = 10;
	localparam int POOL_MAX   = (SLOT_DEPTH_DEF < INDEX_SPAN) ? SLOT_DEPTH_DEF : INDEX_SPAN;

	// first member sits in the top bits, so this matches the result layout
	typedef struct packed {
		logic [CNT_W-1:0]  total;
		logic [ADDR_W-1:0] addr;
		logic [IDX_W-1:0]  slot;
		logic [ST_W-1:0]   status;
	} slot_result_t;

	logic [CAP_W-1:0]  capacity_reg;
	logic [OBJ_W-1:0]  stride_reg;
	logic [ADDR_W-1:0] base_reg;
	logic [IDX_W-1:0]  freed_slots [POOL_MAX];
	logic              slot_live   [POOL_MAX];
	int unsigned       freed_count;
	int unsigned       fresh_top;
	int unsigned       live_count;
	int                fail_total;
	int                result_total;
	slot_result_t      pending_results [$];

	function automatic int unsigned pool_size();
		return (capacity_reg > POOL_MAX) ? POOL_MAX : int'(capacity_reg);
	endfunction

	function automatic logic [ADDR_W-1:0] byte_address(input int unsigned slot);
		return base_reg + ADDR_W'(slot) * ADDR_W'(stride_reg);
	endfunction

	function automatic void empty_pool();
		foreach (slot_live[i]) slot_live[i] = 1'b0;
		freed_count = 0;
		live_count  = 0;
		fresh_top   = pool_size();
	endfunction

	function automatic slot_result_t execute_command(input logic [OP_W-1:0] opcode,
			input logic [IDX_W-1:0] entry);
		slot_result_t res;
		int unsigned  size;
		int unsigned  slot;
		int unsigned  start;
		logic         taken;
		logic         hit;
		res  = '0;
		size = pool_size();
		slot = 0;
		case (opcode)
		OP_ALLOC: begin
			// freed slots first, newest first; then fresh ones from the top down
			taken = 1'b1;
			if (freed_count > 0) begin
				freed_count--;
				slot = freed_slots[freed_count];
			end else if (fresh_top > 0) begin
				fresh_top--;
				slot = fresh_top;
			end else begin
				taken = 1'b0;
			end
			if (taken && slot < size) begin
				slot_live[slot] = 1'b1;
				live_count++;
				res.slot = IDX_W'(slot);
				res.addr = byte_address(slot);
			end else begin
				res.status = ST_EMPTY;
			end
		end
		OP_FREE: begin
			if (entry >= size) begin
				res.status = ST_RANGE;
			end else if (!slot_live[entry]) begin
				res.status = ST_NOTACT;
			end else if (freed_count < POOL_MAX) begin
				slot_live[entry] = 1'b0;
				freed_slots[freed_count] = entry;
				freed_count++;
				if (live_count > 0) live_count--;
			end
		end
		OP_FIRST, OP_NEXT: begin
			start = (opcode == OP_NEXT) ? int'(entry) + 1 : 0;
			hit   = 1'b0;
			for (int unsigned i = start; i < size && !hit; i++) begin
				if (slot_live[i]) begin
					hit  = 1'b1;
					slot = i;
				end
			end
			if (hit) begin
				res.slot = IDX_W'(slot);
				res.addr = byte_address(slot);
			end else begin
				res.status = ST_NONE;
			end
		end
		OP_CLEAR: empty_pool();
		OP_ADDR: begin
			if (entry >= size) begin
				res.status = ST_RANGE;
			end else begin
				res.slot = entry;
				res.addr = byte_address(entry);
			end
		end
		default: ;
		endcase
		res.total = CNT_W'(live_count);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_result_t want;
		slot_result_t got;
		if (!arst_n) begin
			capacity_reg = CAP_RESET;
			stride_reg   = OBJ_RESET;
			base_reg     = BASE_RESET;
			empty_pool();
			pending_results.delete();
			fail_total   = 0;
			result_total = 0;
			mismatches   <= 0;
			awaited      <= 0;
			checked      <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				CFG_CAPACITY: begin
					capacity_reg = cfg_wdata[CAP_W-1:0];
					empty_pool();
				end
				CFG_OBJ_SIZE: stride_reg = cfg_wdata[OBJ_W-1:0];
				CFG_BASE:     base_reg   = cfg_wdata[ADDR_W-1:0];
				default: ;
				endcase
			end
			// compare before pushing, so a result can never meet its own command
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(slot_result_t)-1:0];
				result_total++;
				if (pending_results.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_MAX)
						$display("%m: unexpected result st=%0d idx=%0d addr=%h tot=%0d",
							got.status, got.slot, got.addr, got.total);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						fail_total++;
						if (fail_total <= REPORT_MAX) begin
							$write("%m: result %0d exp st=%0d idx=%0d addr=%h tot=%0d,",
								result_total, want.status, want.slot, want.addr,
								want.total);
							$display(" got st=%0d idx=%0d addr=%h tot=%0d",
								got.status, got.slot, got.addr, got.total);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(execute_command(s_tdata[OP_W-1:0],
					s_tdata[OP_W+IDX_W-1:OP_W]));
			mismatches <= fail_total;
			awaited    <= pending_results.size();
			checked    <= result_total;
		end
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives commands and register writes into the slot manager with bursty
// input and an uneven result stall pattern; a side checker predicts and
// compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import opsm_pkg::*;

	// opcodes the block leaves unused; they must answer ok with the count
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	// result stall patterns
	localparam int RX_OPEN     = 0;
	localparam int RX_COIN     = 1;
	localparam int RX_SPARSE   = 2;
	localparam int RX_PERIODIC = 3;

	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 84;
	// cycles with no item moving and no register write before giving up
	localparam int QUIET_LIMIT   = 4000;
	// settle time after the last result
	localparam int DRAIN_CYCLES  = 20;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CFGIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata   = '0;  // opcode[2:0], entry_index[10:3], zero pad
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OUT_W-1:0]    m_tdata;         // status[2:0], result_index[10:3],
	                                      // slot_address[42:11], active_total[51:43]

	int          mismatches;
	int          awaited;
	int          checked;
	int          burst_left    = 0;
	int          commands_sent = 0;
	int          settings_used = 1;
	int unsigned pool_slots    = INDEX_SPAN;
	int          stall_mode    = RX_OPEN;
	int          stall_left    = 0;
	int          quiet_cycles  = 0;

	object_pool_slot_manager uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	slot_result_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.awaited    (awaited),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: hold one stall pattern for a while, then pick another.
	// The open pattern gives long stretches with no back-pressure at all.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(RX_OPEN, RX_PERIODIC);
			stall_left = $urandom_range(16, 160);
		end else begin
			stall_left--;
		end
		case (stall_mode)
		RX_OPEN:   m_tready <= 1'b1;
		RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
		RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
		default:   m_tready <= ((stall_left % 24) >= 16);
		endcase
	end

	// Watchdog: count cycles in which nothing is accepted or written
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("tb: quiet for %0d cycles with %0d results outstanding", QUIET_LIMIT, awaited);
		$display("tb: FAIL");
		$finish;
	end

	// Present one command and hold it until the block takes it. Commands go
	// out in bursts; between bursts drop valid for a random gap, so gaps land
	// on every step of the block's idle, execute and done sequence. Within a burst valid
	// stays high from one item to the next.
	task automatic send_command(input logic [OP_W-1:0] opcode, input logic [IDX_W-1:0] entry);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - OP_W - IDX_W){1'b0}}, entry, opcode};
		do @(posedge clk); while (!s_tready);
		commands_sent++;
	endtask

	// Drop valid and wait for every outstanding result. The first edge lets
	// the checker count the item taken in this very step.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
	endtask

	// Write all three registers once the pool is idle; the capacity write
	// also empties the pool.
	task automatic configure(input int unsigned capacity, input logic [OBJ_W-1:0] stride,
			input logic [ADDR_W-1:0] base);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CAPACITY;
		cfg_wdata <= CFG_W'(capacity);
		@(posedge clk);
		cfg_index <= CFG_OBJ_SIZE;
		cfg_wdata <= CFG_W'(stride);
		@(posedge clk);
		cfg_index <= CFG_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_we    <= 1'b0;
		pool_slots = (capacity > INDEX_SPAN) ? INDEX_SPAN : capacity;
		settings_used++;
	endtask

	// Mostly well-formed traffic: allocations, frees aimed at the top of the
	// pool where fresh slots are handed out, and searches and address lookups
	// near live slots. The rest is random indices, clears and unused opcodes.
	task automatic random_command();
		int unsigned pick;
		int unsigned top;
		int unsigned reach;
		int unsigned aimed;
		int unsigned below;
		logic [IDX_W-1:0] wild;
		pick  = $urandom_range(0, 99);
		top   = (pool_slots == 0) ? 0 : pool_slots - 1;
		reach = $urandom_range(0, 15);
		if (reach > top) reach = top;
		aimed = top - reach;
		below = $urandom_range(0, top);
		wild  = IDX_W'($urandom_range(0, INDEX_SPAN - 1));
		if (pick < 36)
			send_command(OP_ALLOC, wild);
		else if (pick < 58)
			send_command(OP_FREE, IDX_W'(aimed));
		else if (pick < 63)
			send_command(OP_FREE, wild);
		else if (pick < 70)
			send_command(OP_FIRST, wild);
		else if (pick < 80)
			send_command(OP_NEXT, $urandom_range(0, 1) ? IDX_W'(aimed) : wild);
		else if (pick < 90)
			send_command(OP_ADDR, $urandom_range(0, 1) ? IDX_W'(below) : wild);
		else if (pick < 93)
			send_command(OP_CLEAR, wild);
		else
			send_command($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI, wild);
	endtask

	initial begin
		int unsigned       capacity;
		logic [OBJ_W-1:0]  stride;
		logic [ADDR_W-1:0] base;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: full pool of 256, stride 64, base 0
		send_command(OP_FIRST, 8'd0);         // empty pool, nothing to find
		send_command(OP_ALLOC, 8'd0);         // fresh slot from the top
		send_command(OP_ALLOC, 8'hFF);
		send_command(OP_ADDR, 8'd0);
		send_command(OP_ADDR, 8'hFF);
		send_command(OP_NEXT, 8'd0);
		send_command(OP_NEXT, 8'hFF);         // search starts past the end
		send_command(OP_FREE, 8'd254);
		send_command(OP_FREE, 8'd254);        // already inactive
		send_command(OP_ALLOC, 8'd0);         // reuses the slot just freed
		send_command(OP_FIRST, 8'd0);
		send_command(OP_SPARE_LO, 8'hFF);
		send_command(OP_SPARE_HI, 8'd0);
		send_command(OP_CLEAR, 8'd0);

		// One slot, widest stride, base at the very top
		configure(1, 16'hFFFF, 32'hFFFF_FFFF);
		send_command(OP_ALLOC, 8'd0);
		send_command(OP_ALLOC, 8'd0);         // pool exhausted
		send_command(OP_FREE, 8'd1);          // outside the pool
		send_command(OP_ADDR, 8'd1);
		send_command(OP_FREE, 8'd0);
		send_command(OP_ALLOC, 8'd0);

		// A pool with no slots at all
		configure(0, 16'd1, 32'd0);
		send_command(OP_ALLOC, 8'd0);
		send_command(OP_ADDR, 8'd0);
		send_command(OP_FIRST, 8'd0);

		// Capacity beyond the index span saturates at 256
		configure(9'h1FF, 16'hFFFF, 32'hFFFF_0000);
		send_command(OP_ADDR, 8'hFF);
		send_command(OP_ALLOC, 8'd0);

		// Random phases, each with fresh register values
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0)
				capacity = INDEX_SPAN;
			else if (phase == 1)
				capacity = 2;
			else if (phase == 2)
				capacity = $urandom_range(INDEX_SPAN + 1, (1 << CAP_W) - 1);
			else
				case ($urandom_range(0, 5))
				0:       capacity = 1;
				1:       capacity = INDEX_SPAN;
				2, 3:    capacity = $urandom_range(3, 16);
				default: capacity = $urandom_range(17, 64);
				endcase
			case ($urandom_range(0, 3))
			0:       stride = 16'd1;
			1:       stride = 16'hFFFF;
			default: stride = OBJ_W'($urandom_range(1, 16'hFFFF));
			endcase
			case ($urandom_range(0, 3))
			0:       base = '0;
			1:       base = '1;
			default: base = $urandom;
			endcase
			configure(capacity, stride, base);
			repeat (PHASE_ITEMS) random_command();
		end

		// Let every result arrive, then watch a little longer for strays
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d commands under %0d register settings, %0d results checked",
			commands_sent, settings_used, checked);
		$display("tb: pool sizes from none to saturated, slot reuse and address wrap covered");
		if (mismatches == 0 && awaited == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
